/* hw/rtl/efp_pkg.sv */
// Shared constants, types and a helper function of the escaped frame parser.
`default_nettype none

package efp_pkg;

  localparam int MAX_DATA    = 32;
  localparam int NUM_TYPES   = 4;
  localparam int TABLE_SLOTS = 4;
  localparam int DATA_AW     = $clog2(MAX_DATA);
  localparam int LEN_W       = 6;
  localparam int STORE_AW    = DATA_AW + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = $clog2(OUT_DEPTH);
  localparam int OUT_CW      = OUT_AW + 1;
  localparam int ADDR_W      = 5;

  localparam logic [1:0] PS_START   = 2'd0;
  localparam logic [1:0] PS_LABEL   = 2'd1;
  localparam logic [1:0] PS_PAYLOAD = 2'd2;
  localparam logic [1:0] PS_END     = 2'd3;

  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_NO_START      = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_LABEL = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM      = 3'd3;
  localparam logic [2:0] ERR_NO_END        = 3'd4;

  localparam logic [2:0] REG_START_FLAG     = 3'd0;
  localparam logic [2:0] REG_END_FLAG       = 3'd1;
  localparam logic [2:0] REG_ESCAPE_FLAG    = 3'd2;
  localparam logic [2:0] REG_LABEL_TABLE    = 3'd3;
  localparam logic [2:0] REG_LENGTH_TABLE   = 3'd4;
  localparam logic [2:0] REG_TYPES_IN_USE   = 3'd5;
  localparam logic [2:0] REG_RESERVED_LABEL = 3'd6;

  typedef struct packed {
    logic [7:0]  open_code;
    logic [7:0]  close_code;
    logic [7:0]  esc_code;
    logic [31:0] label_table;
    logic [23:0] length_table;
    logic [2:0]  types_in_use;
    logic [7:0]  reserved_label;
  } cfg_t;

  typedef struct packed {
    logic             is_frame;
    logic [1:0]       parse_state;
    logic [2:0]       error_code;
    logic [1:0]       type_index;
    logic [LEN_W-1:0] len;
    logic             bank;
  } cmd_t;

  typedef struct packed {
    logic               we;
    logic               bank;
    logic [DATA_AW-1:0] addr;
    logic [7:0]         data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [1:0] parse_state;
    logic [2:0] error_code;
    logic       message_ok;
    logic [1:0] type_index;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;
  } res_t;

  function automatic logic [LEN_W-1:0] entry_length(input logic [23:0] lengths,
                                                    input logic [1:0] idx);
    logic [23:0]      sh;
    logic [LEN_W-1:0] len;
    sh  = lengths >> (6 * idx);
    len = sh[LEN_W-1:0];
    if (len > LEN_W'(MAX_DATA)) begin
      len = LEN_W'(MAX_DATA);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/escaped_frame_parser.sv */
// Top level of the escaped frame parser: configuration registers and the two halves.
//
//  Channel   Handshake                  Payload
//  cfg       psel penable pwrite pready paddr pwdata prdata
//  input     push / full                rx_byte
//  result    empty / pop                parse_state error_code message_ok type_index
//                                       payload_byte payload_valid last
//
// The front end takes one byte a cycle while full is low. Each command passes through the
// command queue, the back end's result register and the output queue to the result ports.
// A closing end flag yields one result per payload byte, read from the payload bank
// one a cycle while the output queue has room. The front end stalls on payload bytes
// while the bank it fills is still being read out. Input is taken while the four-entry
// command queue has room; results wait in a four-entry output queue. Reset is synchronous
// and sets the registers to their defaults; the banks need no clearing.
`default_nettype none

module escaped_frame_parser import efp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              push,
  output logic                   full,
  output logic [1:0]             parse_state,
  output logic [2:0]             error_code,
  output logic                   message_ok,
  output logic [1:0]             type_index,
  output logic [7:0]             payload_byte,
  output logic                   payload_valid,
  output logic                   last,
  output logic                   empty,
  input  wire logic              pop
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       cfg_write;

  logic       q_full, q_empty, q_pop, cmd_push;
  cmd_t       cmd, q_head;
  wr_t        wr;
  rel_t       rel;
  res_t       res;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_code      <= 8'd126;
      cfg.close_code     <= 8'd127;
      cfg.esc_code       <= 8'd125;
      cfg.label_table    <= '0;
      cfg.length_table   <= '0;
      cfg.types_in_use   <= '0;
      cfg.reserved_label <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_START_FLAG:     cfg.open_code      <= pwdata[7:0];
        REG_END_FLAG:       cfg.close_code     <= pwdata[7:0];
        REG_ESCAPE_FLAG:    cfg.esc_code       <= pwdata[7:0];
        REG_LABEL_TABLE:    cfg.label_table    <= pwdata;
        REG_LENGTH_TABLE:   cfg.length_table   <= pwdata[23:0];
        REG_TYPES_IN_USE:   cfg.types_in_use   <= pwdata[2:0];
        REG_RESERVED_LABEL: cfg.reserved_label <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_FLAG:     prdata = {24'd0, cfg.open_code};
      REG_END_FLAG:       prdata = {24'd0, cfg.close_code};
      REG_ESCAPE_FLAG:    prdata = {24'd0, cfg.esc_code};
      REG_LABEL_TABLE:    prdata = cfg.label_table;
      REG_LENGTH_TABLE:   prdata = {8'd0, cfg.length_table};
      REG_TYPES_IN_USE:   prdata = {29'd0, cfg.types_in_use};
      REG_RESERVED_LABEL: prdata = {24'd0, cfg.reserved_label};
      default:            prdata = '0;
    endcase
  end

  efp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_byte  (rx_byte),
    .push     (push),
    .full     (full),
    .q_full   (q_full),
    .cmd_push (cmd_push),
    .cmd      (cmd),
    .wr       (wr),
    .rel      (rel)
  );

  efp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  efp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .wr      (wr),
    .rel     (rel),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign parse_state   = res.parse_state;
  assign error_code    = res.error_code;
  assign message_ok    = res.message_ok;
  assign type_index    = res.type_index;
  assign payload_byte  = res.payload_byte;
  assign payload_valid = res.payload_valid;
  assign last          = res.last;

endmodule

`default_nettype wire

/* hw/rtl/efp_front.sv */
// Front end: accepts received bytes, runs the frame parser and fills the payload banks.
`default_nettype none

module efp_front import efp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic [7:0] rx_byte,
  input  wire logic       push,
  output logic            full,
  input  wire logic       q_full,
  output logic            cmd_push,
  output cmd_t            cmd,
  output wr_t             wr,
  input  wire rel_t       rel
);

  typedef enum logic [1:0] {
    S_START   = PS_START,
    S_LABEL   = PS_LABEL,
    S_PAYLOAD = PS_PAYLOAD,
    S_END     = PS_END
  } state_t;

  state_t           state, state_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic             escape_pending, escape_pending_next;
  logic [1:0]       matched_type, matched_type_next;
  logic             bank, bank_next;
  logic [1:0]       busy, busy_next;

  logic             accept;
  logic             found;
  logic [1:0]       match_idx;
  logic [LEN_W-1:0] cur_len;
  logic [2:0]       err;
  logic [1:0]       busy_set, busy_clr;

  assign full     = q_full || (state == S_PAYLOAD && busy[bank]);
  assign accept   = push && !full;
  assign cmd_push = accept;
  assign cur_len  = entry_length(cfg.length_table, matched_type);

  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    if (rx_byte != cfg.reserved_label) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (!found && i < int'(cfg.types_in_use) && i < NUM_TYPES &&
            cfg.label_table[8*i +: 8] == rx_byte) begin
          found     = 1'b1;
          match_idx = 2'(i);
        end
      end
    end
  end

  always_comb begin
    state_next          = state;
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    escape_pending_next = escape_pending;
    matched_type_next   = matched_type;
    bank_next           = bank;
    err                 = ERR_NONE;
    cmd                 = '0;
    cmd.bank            = bank;
    cmd.type_index      = matched_type;
    wr.we               = 1'b0;
    wr.bank             = bank;
    wr.addr             = byte_count[DATA_AW-1:0];
    wr.data             = rx_byte;
    unique case (state)
      S_START: begin
        if (rx_byte == cfg.open_code) begin
          state_next = S_LABEL;
        end else begin
          err = ERR_NO_START;
        end
      end
      S_LABEL: begin
        if (found) begin
          state_next          = S_PAYLOAD;
          byte_count_next     = '0;
          running_xor_next    = rx_byte;
          escape_pending_next = 1'b0;
          matched_type_next   = match_idx;
        end else begin
          err        = ERR_UNKNOWN_LABEL;
          state_next = S_START;
        end
      end
      S_PAYLOAD: begin
        if (byte_count >= cur_len && (escape_pending || rx_byte != cfg.esc_code)) begin
          if (rx_byte == running_xor) begin
            state_next = S_END;
          end else begin
            err        = ERR_CHECKSUM;
            state_next = S_START;
          end
        end else if (!escape_pending && rx_byte == cfg.esc_code) begin
          escape_pending_next = 1'b1;
        end else begin
          wr.we               = byte_count < LEN_W'(MAX_DATA);
          byte_count_next     = byte_count + LEN_W'(1);
          running_xor_next    = running_xor ^ rx_byte;
          escape_pending_next = 1'b0;
        end
      end
      S_END: begin
        state_next = S_START;
        if (rx_byte == cfg.close_code) begin
          cmd.is_frame = 1'b1;
          cmd.len      = cur_len;
          bank_next    = !bank;
        end else begin
          err = ERR_NO_END;
        end
      end
      default: state_next = S_START;
    endcase
    cmd.parse_state = 2'(state_next);
    cmd.error_code  = err;
    wr.we           = wr.we && accept;
  end

  always_comb begin
    busy_set = '0;
    busy_clr = '0;
    if (accept && cmd.is_frame) begin
      busy_set[bank] = 1'b1;
    end
    if (rel.valid) begin
      busy_clr[rel.bank] = 1'b1;
    end
    busy_next = (busy | busy_set) & ~busy_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_START;
      byte_count     <= '0;
      running_xor    <= '0;
      escape_pending <= 1'b0;
      matched_type   <= '0;
      bank           <= 1'b0;
      busy           <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        state          <= state_next;
        byte_count     <= byte_count_next;
        running_xor    <= running_xor_next;
        escape_pending <= escape_pending_next;
        matched_type   <= matched_type_next;
        bank           <= bank_next;
      end
    end
  end

  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("A payload bank was released that was not held.");

  a_frame_free_bank: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.is_frame) |-> !busy[cmd.bank])
    else $error("A frame was completed into a bank still being read.");

endmodule

`default_nettype wire

/* hw/rtl/efp_queue.sv */
// Short command queue between the parser front end and the readout back end.
`default_nettype none

module efp_queue import efp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr, rptr;
  logic [QUEUE_CW-1:0] count;

  assign full  = count == QUEUE_CW'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      count <= count + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("An item was pushed into a full command queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("The command queue count ran past its depth.");

endmodule

`default_nettype wire

/* hw/rtl/efp_back.sv */
// Back end: holds the payload banks and turns commands into result items.
`default_nettype none

module efp_back import efp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  input  wire wr_t  wr,
  output rel_t      rel,
  output logic      empty,
  input  wire logic pop,
  output res_t      res
);

  logic [7:0]          mem [2*MAX_DATA];
  logic [7:0]          rdata;
  logic [STORE_AW-1:0] raddr;

  logic [LEN_W-1:0]    k;
  logic                is_data;
  logic                is_last;
  logic                issue;

  logic                r_valid;
  logic                r_use_mem;
  res_t                r_res;
  res_t                push_res;

  res_t                ofifo [OUT_DEPTH];
  logic [OUT_AW-1:0]   wptr, rptr;
  logic [OUT_CW-1:0]   count;
  logic                do_pop;

  assign is_data = q_head.is_frame && q_head.len != '0;
  assign is_last = !is_data || (k == q_head.len - LEN_W'(1));
  assign issue   = !q_empty && ((count + OUT_CW'(r_valid)) < OUT_CW'(OUT_DEPTH));
  assign q_pop   = issue && is_last;
  assign raddr   = {q_head.bank, k[DATA_AW-1:0]};

  assign rel.valid = q_pop && q_head.is_frame;
  assign rel.bank  = q_head.bank;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[{wr.bank, wr.addr}] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r_use_mem           <= is_data;
      r_res.parse_state   <= q_head.is_frame ? PS_START : q_head.parse_state;
      r_res.error_code    <= q_head.is_frame ? ERR_NONE : q_head.error_code;
      r_res.message_ok    <= q_head.is_frame;
      r_res.type_index    <= q_head.is_frame ? q_head.type_index : 2'd0;
      r_res.payload_byte  <= '0;
      r_res.payload_valid <= is_data;
      r_res.last          <= is_last;
    end
  end

  always_comb begin
    push_res              = r_res;
    push_res.payload_byte = r_use_mem ? rdata : 8'd0;
  end

  assign empty  = count == '0;
  assign do_pop = pop && !empty;
  assign res    = ofifo[rptr];

  always_ff @(posedge clk) begin
    if (r_valid) begin
      ofifo[wptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      r_valid <= 1'b0;
      wptr    <= '0;
      rptr    <= '0;
      count   <= '0;
    end else begin
      r_valid <= issue;
      if (issue) begin
        k <= is_last ? '0 : k + LEN_W'(1);
      end
      if (r_valid) begin
        wptr <= wptr + OUT_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + OUT_AW'(1);
      end
      count <= count + OUT_CW'(r_valid) - OUT_CW'(do_pop);
    end
  end

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (issue && is_data) |-> k < q_head.len)
    else $error("A payload read went past the frame length.");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    $past(r_valid) |-> !empty)
    else $error("A read result did not reach the output queue.");

endmodule

`default_nettype wire
